[src/audio_gain_fade_envelope_unit_macros.svh]
// Assertion macros for the gain fade envelope unit.
// Depends on nothing; users provide clk and rst in scope.
`ifndef AUDIO_GAIN_FADE_ENVELOPE_UNIT_MACROS_SVH
`define AUDIO_GAIN_FADE_ENVELOPE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FAGE_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define FAGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FAGE_ASSERT(lbl, expr, msg)
`define FAGE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/fage_pkg.sv]
// Shared types, register indexes and constants of the gain fade envelope unit.
// Depends on nothing.
package fage_pkg;

  localparam int FRAME_BITS_DEFAULT   = 24;
  localparam int MAX_CHANNELS_DEFAULT = 8;

  localparam int SAMPLE_W    = 16;
  localparam int RAMP_W      = 24;
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = SAMPLE_W / 2;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN            = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_IN_FRAMES  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_OUT_FRAMES = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_FRAMES    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_IN_ENABLE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_OUT_ENABLE = 3'd6;

  localparam logic [1:0] PHASE_FADE_IN  = 2'd0;
  localparam logic [1:0] PHASE_STEADY   = 2'd1;
  localparam logic [1:0] PHASE_FADE_OUT = 2'd2;
  localparam logic [1:0] PHASE_PAST_END = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  localparam logic [GAIN_W-1:0] GAIN_RESET         = 16'd256;
  localparam logic [RAMP_W-1:0] TOTAL_FRAMES_RESET = 24'hFFFFFF;
  localparam logic [3:0]        CHANNEL_RESET      = 4'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [1:0]                 phase;
    logic                       clipped;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [RAMP_W-1:0] fade_in_frames;
    logic [RAMP_W-1:0] fade_out_frames;
    logic [RAMP_W-1:0] total_frames;
    logic [3:0]        channel_count;
    logic              fade_in_enable;
    logic              fade_out_enable;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mag;
    logic                neg;
    logic                past_end;
    logic                fade_in;
    logic                fade_out;
    logic [RAMP_W-1:0]   num_in;
    logic [RAMP_W-1:0]   num_out;
    logic [1:0]          phase;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_GAIN,
    BK_SAT
  } back_state_t;

endpackage

[src/fage_front.sv]
// Front end: accepts samples, tracks frame and channel position, classifies the ramp phase.
// Depends on fage_pkg.
module fage_front #(
  parameter int FRAME_BITS   = fage_pkg::FRAME_BITS_DEFAULT,
  parameter int MAX_CHANNELS = fage_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  fage_pkg::cfg_t  cfg,
  input  logic            item_valid,
  output logic            item_stall,
  input  fage_pkg::item_t item,
  output logic            push,
  output fage_pkg::cmd_t  cmd,
  input  logic            queue_full
);

  localparam int CW     = (FRAME_BITS > fage_pkg::RAMP_W) ? FRAME_BITS : fage_pkg::RAMP_W;
  localparam int CH_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);
  localparam logic [CW-1:0] FRAME_MASK = CW'({FRAME_BITS{1'b1}});

  logic [FRAME_BITS-1:0] frame_counter;
  logic [CH_BITS-1:0]    channel_counter;

  logic [FRAME_BITS-1:0] f_eff;
  logic [CH_BITS-1:0]    ch_eff;
  logic [CW-1:0]         f_w;
  logic [CW-1:0]         tot_w;
  logic [CW-1:0]         lim;
  logic [CW-1:0]         remain;
  logic [4:0]            ch_lim;
  logic [4:0]            ch_inc;
  logic                  wrap;
  logic                  past_end;
  logic                  fin;
  logic                  fout;
  logic [fage_pkg::SAMPLE_W-1:0] raw;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  assign f_eff  = item.restart ? '0 : frame_counter;
  assign ch_eff = item.restart ? '0 : channel_counter;
  assign f_w    = CW'(f_eff);
  assign tot_w  = CW'(cfg.total_frames);
  assign lim    = (tot_w < FRAME_MASK) ? tot_w : FRAME_MASK;
  assign remain = tot_w - f_w - CW'(1);

  always_comb begin
    if (cfg.channel_count == 4'd0) begin
      ch_lim = 5'd1;
    end else if ({1'b0, cfg.channel_count} > MAX_CH) begin
      ch_lim = MAX_CH;
    end else begin
      ch_lim = {1'b0, cfg.channel_count};
    end
  end

  assign ch_inc = 5'(ch_eff) + 5'd1;
  assign wrap   = ch_inc >= ch_lim;

  assign past_end = f_w >= tot_w;
  assign fin  = cfg.fade_in_enable && (cfg.fade_in_frames != '0) &&
                (f_w < CW'(cfg.fade_in_frames));
  assign fout = cfg.fade_out_enable && (cfg.fade_out_frames != '0) &&
                ((cfg.fade_out_frames >= cfg.total_frames) ||
                 (f_w >= CW'(cfg.total_frames - cfg.fade_out_frames)));

  assign raw = item.sample_in;

  always_comb begin
    cmd          = '0;
    cmd.neg      = raw[fage_pkg::SAMPLE_W-1];
    cmd.mag      = cmd.neg ? (fage_pkg::SAMPLE_W'(0) - raw) : raw;
    cmd.past_end = past_end;
    cmd.fade_in  = fin;
    cmd.fade_out = fout;
    cmd.num_in   = f_w[fage_pkg::RAMP_W-1:0];
    cmd.num_out  = remain[fage_pkg::RAMP_W-1:0];
    if (past_end) begin
      cmd.phase = fage_pkg::PHASE_PAST_END;
    end else if (fout) begin
      cmd.phase = fage_pkg::PHASE_FADE_OUT;
    end else if (fin) begin
      cmd.phase = fage_pkg::PHASE_FADE_IN;
    end else begin
      cmd.phase = fage_pkg::PHASE_STEADY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter   <= '0;
      channel_counter <= '0;
    end else if (push) begin
      channel_counter <= wrap ? '0 : ch_inc[CH_BITS-1:0];
      if (wrap && (f_w < lim)) begin
        frame_counter <= f_eff + FRAME_BITS'(1);
      end else begin
        frame_counter <= f_eff;
      end
    end
  end

endmodule

[src/fage_queue.sv]
// Short command queue between the front end and the arithmetic back end.
// Depends on fage_pkg.
module fage_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fage_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output fage_pkg::cmd_t head
);

  localparam int PTR_W = (fage_pkg::QUEUE_DEPTH > 1) ? $clog2(fage_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(fage_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(fage_pkg::QUEUE_DEPTH - 1);

  fage_pkg::cmd_t   slots [fage_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(fage_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[src/fage_back.sv]
// Back end: ramp multiply, two-bit-per-cycle ramp divide, gain, saturation and output register.
// Depends on fage_pkg.
module fage_back (
  input  logic              clk,
  input  logic              rst,
  input  fage_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  fage_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output fage_pkg::result_t result
);

  localparam int SW     = fage_pkg::SAMPLE_W;
  localparam int RW     = fage_pkg::RAMP_W;
  localparam int PW     = SW + RW;
  localparam int GW     = SW + fage_pkg::GAIN_W;
  localparam int STEP_W = $clog2(fage_pkg::DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fage_pkg::DIV_STEPS - 1);

  fage_pkg::back_state_t state;
  fage_pkg::back_state_t state_next;

  fage_pkg::cmd_t    cmd;
  logic [SW-1:0]     dvd;
  logic [RW-1:0]     rem;
  logic [STEP_W-1:0] step_cnt;
  logic              ramp_sel;
  logic [GW-1:0]     gprod;

  logic [RW-1:0]     den;
  logic [RW-1:0]     num;
  logic [PW-1:0]     prod;
  logic [RW:0]       den_x;
  logic [RW:0]       r1;
  logic [RW:0]       s1;
  logic [RW:0]       r2;
  logic [RW:0]       s2;
  logic              ge1;
  logic              ge2;
  logic              out_free;
  logic              load_out;
  logic [GW-9:0]     gmag;
  fage_pkg::result_t sat;

  assign den   = ramp_sel ? cfg.fade_out_frames : cfg.fade_in_frames;
  assign num   = ramp_sel ? cmd.num_out : cmd.num_in;
  assign prod  = PW'(dvd) * PW'(num);
  assign den_x = {1'b0, den};

  assign r1  = {rem, dvd[SW-1]};
  assign ge1 = r1 >= den_x;
  assign s1  = ge1 ? (r1 - den_x) : r1;
  assign r2  = {s1[RW-1:0], dvd[SW-2]};
  assign ge2 = r2 >= den_x;
  assign s2  = ge2 ? (r2 - den_x) : r2;

  assign out_free = !result_valid || !result_stall;
  assign gmag     = gprod[GW-1:8];

  always_comb begin
    sat = '0;
    if (cmd.past_end) begin
      sat.phase = fage_pkg::PHASE_PAST_END;
    end else begin
      sat.phase = cmd.phase;
      if (!cmd.neg) begin
        if (gmag > (GW-8)'(fage_pkg::SAMPLE_MAX)) begin
          sat.sample_out = fage_pkg::SAMPLE_MAX;
          sat.clipped    = 1'b1;
        end else begin
          sat.sample_out = gmag[SW-1:0];
        end
      end else begin
        if (gmag > (GW-8)'(32768)) begin
          sat.sample_out = fage_pkg::SAMPLE_MIN;
          sat.clipped    = 1'b1;
        end else begin
          sat.sample_out = SW'(0) - gmag[SW-1:0];
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fage_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_head.past_end) begin
            state_next = fage_pkg::BK_SAT;
          end else if (q_head.fade_in || q_head.fade_out) begin
            state_next = fage_pkg::BK_MUL;
          end else begin
            state_next = fage_pkg::BK_GAIN;
          end
        end
      end
      fage_pkg::BK_MUL: begin
        state_next = fage_pkg::BK_DIV;
      end
      fage_pkg::BK_DIV: begin
        if (step_cnt == LAST_STEP) begin
          if (!ramp_sel && cmd.fade_out) begin
            state_next = fage_pkg::BK_MUL;
          end else begin
            state_next = fage_pkg::BK_GAIN;
          end
        end
      end
      fage_pkg::BK_GAIN: begin
        state_next = fage_pkg::BK_SAT;
      end
      fage_pkg::BK_SAT: begin
        if (out_free) begin
          state_next = fage_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = fage_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      fage_pkg::BK_IDLE: begin
        q_pop = q_valid;
      end
      fage_pkg::BK_SAT: begin
        load_out = out_free;
      end
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fage_pkg::BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fage_pkg::BK_IDLE: begin
        if (q_pop) begin
          cmd      <= q_head;
          dvd      <= q_head.mag;
          ramp_sel <= !q_head.fade_in;
        end
      end
      fage_pkg::BK_MUL: begin
        rem      <= prod[PW-1:SW];
        dvd      <= prod[SW-1:0];
        step_cnt <= '0;
      end
      fage_pkg::BK_DIV: begin
        rem      <= s2[RW-1:0];
        dvd      <= {dvd[SW-3:0], ge1, ge2};
        step_cnt <= step_cnt + STEP_W'(1);
        if (step_cnt == LAST_STEP) begin
          ramp_sel <= 1'b1;
        end
      end
      fage_pkg::BK_GAIN: begin
        gprod <= GW'(dvd) * GW'(cfg.gain);
      end
      fage_pkg::BK_SAT: begin
        if (load_out) begin
          result <= sat;
        end
      end
      default: begin
        step_cnt <= '0;
      end
    endcase
  end

endmodule

[src/audio_gain_fade_envelope_unit.sv]
// Top level of the gain fade envelope unit: configuration registers, front end, queue, back end.
// Depends on fage_pkg, fage_front, fage_queue, fage_back and the assertion macro header.
//
// Scales interleaved signed 16-bit PCM by a linear per-frame fade-in and fade-out ramp and a
// Q8.8 gain, truncating toward zero and saturating to 16 bits; each sample yields one result
// with its phase and a clip flag. The front end takes a sample every cycle into a two-entry
// queue unless it is full; the back end takes one past the end from idle to saturation, one
// with no ramp via gain and saturation, one with ramps via a multiply and divide per ramp first,
// the divider retiring two quotient bits a cycle. A finished result waits in the output register
// while the next sample is worked on. Write configuration only while no sample is in flight.
`include "audio_gain_fade_envelope_unit_macros.svh"

module audio_gain_fade_envelope_unit #(
  parameter int FRAME_BITS   = fage_pkg::FRAME_BITS_DEFAULT,
  parameter int MAX_CHANNELS = fage_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fage_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fage_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  fage_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output fage_pkg::result_t                  result
);

  fage_pkg::cfg_t cfg;
  fage_pkg::cmd_t push_cmd;
  fage_pkg::cmd_t q_head;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           out_past_end;
  logic           out_zero;
  logic           out_on_rail;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain            <= fage_pkg::GAIN_RESET;
      cfg.fade_in_frames  <= '0;
      cfg.fade_out_frames <= '0;
      cfg.total_frames    <= fage_pkg::TOTAL_FRAMES_RESET;
      cfg.channel_count   <= fage_pkg::CHANNEL_RESET;
      cfg.fade_in_enable  <= 1'b0;
      cfg.fade_out_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fage_pkg::REG_GAIN:            cfg.gain            <= cfg_data[15:0];
        fage_pkg::REG_FADE_IN_FRAMES:  cfg.fade_in_frames  <= cfg_data[23:0];
        fage_pkg::REG_FADE_OUT_FRAMES: cfg.fade_out_frames <= cfg_data[23:0];
        fage_pkg::REG_TOTAL_FRAMES:    cfg.total_frames    <= cfg_data[23:0];
        fage_pkg::REG_CHANNEL_COUNT:   cfg.channel_count   <= cfg_data[3:0];
        fage_pkg::REG_FADE_IN_ENABLE:  cfg.fade_in_enable  <= cfg_data[0];
        fage_pkg::REG_FADE_OUT_ENABLE: cfg.fade_out_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  fage_front #(
    .FRAME_BITS   (FRAME_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .cmd        (push_cmd),
    .queue_full (q_full)
  );

  fage_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  fage_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign out_past_end = result.phase == fage_pkg::PHASE_PAST_END;
  assign out_zero     = (result.sample_out == '0) && !result.clipped;
  assign out_on_rail  = (result.sample_out == fage_pkg::SAMPLE_MAX) ||
                        (result.sample_out == fage_pkg::SAMPLE_MIN);

  `FAGE_ASSERT_NEXT(a_push_lands, item_valid && !item_stall, q_valid, "accepted transaction lost")
  `FAGE_ASSERT(a_past_end_zero, !(result_valid && out_past_end) || out_zero, "past end not zero")
  `FAGE_ASSERT(a_clip_rail, !(result_valid && result.clipped) || out_on_rail, "clip off rail")

endmodule

[tb/audio_gain_fade_envelope_unit_tb.sv]
// Testbench for audio_gain_fade_envelope_unit: drives PCM transactions and checks each
// result against a built-in prediction of the fade envelope, gain and saturation.
// Depends on fage_pkg and the unit's RTL.
`timescale 1ns / 100ps

module audio_gain_fade_envelope_unit_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SEGMENTS    = 17;
  localparam int SEG_ITEMS   = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [fage_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fage_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  fage_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  fage_pkg::result_t result;

  fage_pkg::item_t pending_items[$];
  fage_pkg::result_t expected_results[$];
  fage_pkg::cfg_t cur_cfg;
  longint frame_pos = 0;
  int unsigned chan_pos = 0;
  int send_idle_pct = 17;
  int recv_stall_pct = 53;
  int mismatch_count = 0;
  int cycle_count = 0;

  audio_gain_fade_envelope_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fage_pkg::result_t scale_sample(input fage_pkg::item_t it);
    longint s, v, f, tot, fi, fo, g;
    int unsigned ch;
    logic fin, fout;
    fage_pkg::result_t r;
    if (it.restart) begin
      frame_pos = 0;
      chan_pos = 0;
    end
    s = longint'($signed(it.sample_in));
    f = frame_pos;
    tot = cur_cfg.total_frames;
    fi = cur_cfg.fade_in_frames;
    fo = cur_cfg.fade_out_frames;
    g = cur_cfg.gain;
    ch = cur_cfg.channel_count;
    if (ch == 0) ch = 1;
    if (ch > fage_pkg::MAX_CHANNELS_DEFAULT) ch = fage_pkg::MAX_CHANNELS_DEFAULT;
    r = '0;
    if (f >= tot) begin
      r.phase = fage_pkg::PHASE_PAST_END;
    end else begin
      fin = cur_cfg.fade_in_enable && fi != 0 && f < fi;
      fout = cur_cfg.fade_out_enable && fo != 0 && (fo >= tot || f >= tot - fo);
      v = s;
      if (fin) v = (v * f) / fi;
      if (fout) v = (v * (tot - f - 1)) / fo;
      r.phase = fout ? fage_pkg::PHASE_FADE_OUT :
                (fin ? fage_pkg::PHASE_FADE_IN : fage_pkg::PHASE_STEADY);
      v = (v * g) / 256;
      if (v > longint'(fage_pkg::SAMPLE_MAX)) begin
        v = longint'(fage_pkg::SAMPLE_MAX);
        r.clipped = 1'b1;
      end
      if (v < longint'(fage_pkg::SAMPLE_MIN)) begin
        v = longint'(fage_pkg::SAMPLE_MIN);
        r.clipped = 1'b1;
      end
      r.sample_out = 16'(v);
    end
    chan_pos++;
    if (chan_pos >= ch) begin
      chan_pos = 0;
      if (frame_pos < tot) frame_pos++;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) expected_results.push_back(scale_sample(item));
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transaction: sample %0d phase %0d clipped %0b",
                     result.sample_out, result.phase, result.clipped);
        end else begin
          fage_pkg::result_t want;
          want = expected_results.pop_front();
          if (result.sample_out !== want.sample_out || result.phase !== want.phase ||
              result.clipped !== want.clipped) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b (sample/phase/clip)",
                       want.sample_out, want.phase, want.clipped,
                       result.sample_out, result.phase, result.clipped);
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_sample(input logic signed [fage_pkg::SAMPLE_W-1:0] smp, input logic rs);
    fage_pkg::item_t it;
    it.sample_in = smp;
    it.restart = rs;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fage_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fage_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
  endtask

  task automatic apply_config(input fage_pkg::cfg_t c);
    write_reg(fage_pkg::REG_GAIN, fage_pkg::CFG_DATA_W'(c.gain));
    write_reg(fage_pkg::REG_FADE_IN_FRAMES, c.fade_in_frames);
    write_reg(fage_pkg::REG_FADE_OUT_FRAMES, c.fade_out_frames);
    write_reg(fage_pkg::REG_TOTAL_FRAMES, c.total_frames);
    write_reg(fage_pkg::REG_CHANNEL_COUNT, fage_pkg::CFG_DATA_W'(c.channel_count));
    write_reg(fage_pkg::REG_FADE_IN_ENABLE, fage_pkg::CFG_DATA_W'(c.fade_in_enable));
    write_reg(fage_pkg::REG_FADE_OUT_ENABLE, fage_pkg::CFG_DATA_W'(c.fade_out_enable));
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    fage_pkg::cfg_t seg_cfg;
    logic signed [fage_pkg::SAMPLE_W-1:0] smp;
    logic rs;
    cur_cfg = '{gain: fage_pkg::GAIN_RESET, fade_in_frames: '0, fade_out_frames: '0,
                total_frames: fage_pkg::TOTAL_FRAMES_RESET,
                channel_count: fage_pkg::CHANNEL_RESET,
                fade_in_enable: 1'b0, fade_out_enable: 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unity gain, no ramps
    queue_sample(fage_pkg::SAMPLE_MIN, 1'b1);
    queue_sample(fage_pkg::SAMPLE_MAX, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd1, 1'b0);
    wait_drained();

    // fade-in with maximum gain, enabled fade-out of zero length, run past the end
    apply_config('{gain: 16'hFFFF, fade_in_frames: 24'd3, fade_out_frames: 24'd0,
                   total_frames: 24'd5, channel_count: 4'd1,
                   fade_in_enable: 1'b1, fade_out_enable: 1'b1});
    queue_sample(fage_pkg::SAMPLE_MAX, 1'b1);
    queue_sample(fage_pkg::SAMPLE_MIN, 1'b0);
    queue_sample(16'sd12345, 1'b0);
    queue_sample(-16'sd20000, 1'b0);
    queue_sample(16'sd100, 1'b0);
    queue_sample(16'sd5000, 1'b0);
    queue_sample(fage_pkg::SAMPLE_MIN, 1'b0);
    wait_drained();

    // both ramps, fade-out longer than the clip, channel count zero
    apply_config('{gain: 16'd256, fade_in_frames: 24'd4, fade_out_frames: 24'hFFFFFF,
                   total_frames: 24'd6, channel_count: 4'd0,
                   fade_in_enable: 1'b1, fade_out_enable: 1'b1});
    queue_sample(fage_pkg::SAMPLE_MAX, 1'b1);
    for (int i = 0; i < 6; i++)
      queue_sample(i[0] ? fage_pkg::SAMPLE_MIN : fage_pkg::SAMPLE_MAX, 1'b0);
    wait_drained();

    // empty clip, zero gain, ramps disabled, channel count above the maximum
    apply_config('{gain: 16'd0, fade_in_frames: 24'hFFFFFF, fade_out_frames: 24'hFFFFFF,
                   total_frames: 24'd0, channel_count: 4'd15,
                   fade_in_enable: 1'b0, fade_out_enable: 1'b0});
    queue_sample(fage_pkg::SAMPLE_MAX, 1'b1);
    queue_sample(fage_pkg::SAMPLE_MIN, 1'b0);
    queue_sample(16'sd77, 1'b1);
    wait_drained();

    // enabled ramps of zero length
    apply_config('{gain: 16'd1, fade_in_frames: 24'd0, fade_out_frames: 24'd0,
                   total_frames: 24'd3, channel_count: 4'd3,
                   fade_in_enable: 1'b1, fade_out_enable: 1'b1});
    queue_sample(fage_pkg::SAMPLE_MIN, 1'b1);
    queue_sample(fage_pkg::SAMPLE_MAX, 1'b0);
    queue_sample(-16'sd255, 1'b0);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 6) begin
        send_idle_pct = 17;
        recv_stall_pct = 53;
      end else if (seg < 12) begin
        send_idle_pct = 53;
        recv_stall_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(5))
        0: seg_cfg.gain = 16'($urandom);
        1: seg_cfg.gain = 16'hFFFF;
        default: seg_cfg.gain = 16'($urandom_range(600));
      endcase
      case ($urandom_range(5))
        0: seg_cfg.fade_in_frames = '0;
        1: seg_cfg.fade_in_frames = 24'hFFFFFF;
        default: seg_cfg.fade_in_frames = 24'($urandom_range(40, 1));
      endcase
      case ($urandom_range(5))
        0: seg_cfg.fade_out_frames = '0;
        1: seg_cfg.fade_out_frames = 24'hFFFFFF;
        default: seg_cfg.fade_out_frames = 24'($urandom_range(40, 1));
      endcase
      seg_cfg.total_frames = ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom_range(60));
      seg_cfg.channel_count = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                       : 4'($urandom_range(3, 1));
      seg_cfg.fade_in_enable = ($urandom_range(3) != 0);
      seg_cfg.fade_out_enable = ($urandom_range(3) != 0);
      apply_config(seg_cfg);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        case ($urandom_range(9))
          0: smp = fage_pkg::SAMPLE_MIN;
          1: smp = fage_pkg::SAMPLE_MAX;
          default: smp = 16'($urandom);
        endcase
        rs = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0);
        queue_sample(smp, rs);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/fage_pkg.sv
src/fage_front.sv
src/fage_queue.sv
src/fage_back.sv
src/audio_gain_fade_envelope_unit.sv
tb/audio_gain_fade_envelope_unit_tb.sv
